// ----- rtl/srx_pkg.sv -----
// ----------------------------------------------------------------------------
// srx_pkg - serial receive mid-bit sampler shared definitions
// Types, register indexes and constants used by the sampler core and top.
// ----------------------------------------------------------------------------
package srx_pkg;

   localparam int unsigned BitTicksW   = 16;
   localparam int unsigned TimeoutW    = 24;
   localparam int unsigned OffsetW     = 20;
   localparam int unsigned IdleW       = 17;
   localparam int unsigned BitIndexW   = 4;
   localparam int unsigned CharW       = 8;
   localparam int unsigned CsrIndexW   = 2;
   localparam int unsigned CsrDataW    = 24;

   localparam logic [BitTicksW-1:0] BIT_TICKS_RST     = 16'd417;
   localparam logic                 FRAME_MODE_RST    = 1'b0;
   localparam logic [TimeoutW-1:0]  TIMEOUT_TICKS_RST = 24'd150000;

   localparam logic [TimeoutW-1:0]  HUNT_MAX   = 24'hFFFFFF;
   localparam logic [CharW-1:0]     CHAR7_MASK = 8'h7F;
   localparam logic [CharW-1:0]     CHAR8_MASK = 8'hFF;
   localparam logic [BitIndexW-1:0] NBITS_7E1  = 4'd7;
   localparam logic [BitIndexW-1:0] NBITS_8N1  = 4'd8;
   localparam logic [OffsetW-1:0]   STOP_SLOT  = 20'd9;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_BIT_TICKS     = 2'd0,
      CSR_FRAME_MODE    = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_CONFIRM = 3'd1,
      PH_DATA    = 3'd2,
      PH_STOP    = 3'd3,
      PH_IDLE    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [BitTicksW-1:0] bit_ticks;
      logic                 frame_mode;
      logic [TimeoutW-1:0]  timeout_ticks;
   } srx_cfg_type;

   typedef struct packed {
      logic             valid;
      logic             timed_out;
      logic [CharW-1:0] char_data;
   } srx_result_type;

endpackage

// ----- rtl/srx_core.sv -----
// ----------------------------------------------------------------------------
// srx_core - receive frame tracker
// Holds the frame state and advances it by one line tick when step is high.
// Result for the current tick is presented combinationally.
// ----------------------------------------------------------------------------
module srx_core
   import srx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           rx_level,
   input  srx_cfg_type    cfg,
   output srx_result_type result
);

   phase_type             phase_ff,   phase_in;
   logic [OffsetW-1:0]    offset_ff,  offset_in;
   logic [BitIndexW-1:0]  bit_idx_ff, bit_idx_in;
   logic [CharW-1:0]      shift_ff,   shift_in;
   logic [IdleW-1:0]      idle_ff,    idle_in;
   logic [TimeoutW-1:0]   hunt_ff,    hunt_in;

   logic [BitTicksW-1:0]  half;
   logic [OffsetW-1:0]    offset_inc;
   logic [OffsetW-1:0]    data_target;
   logic [OffsetW-1:0]    stop_target;
   logic [BitIndexW-1:0]  bit_idx_inc;
   logic [BitIndexW-1:0]  nbits;
   logic [IdleW-1:0]      idle_inc;
   logic [IdleW-1:0]      idle_limit;
   logic [TimeoutW-1:0]   hunt_bump;

   assign half        = {1'b0, cfg.bit_ticks[BitTicksW-1:1]};
   assign offset_inc  = offset_ff + 1'b1;
   assign bit_idx_inc = bit_idx_ff + 1'b1;
   // data bit i is sampled at (i+1)*bit + bit/2
   assign data_target = ({16'd0, bit_idx_inc} * {4'd0, cfg.bit_ticks}) + {4'd0, half};
   assign stop_target = (STOP_SLOT * {4'd0, cfg.bit_ticks}) + {4'd0, half};
   assign nbits       = cfg.frame_mode ? NBITS_8N1 : NBITS_7E1;
   assign idle_inc    = idle_ff + 1'b1;
   assign idle_limit  = {cfg.bit_ticks, 1'b0};
   assign hunt_bump   = (hunt_ff == HUNT_MAX) ? hunt_ff : hunt_ff + 1'b1;

   // result of this tick
   always_comb begin
      result.valid     = 1'b0;
      result.timed_out = 1'b0;
      result.char_data = shift_ff & (cfg.frame_mode ? CHAR8_MASK : CHAR7_MASK);
      unique case (phase_ff)
         PH_HUNT: begin
            if (hunt_ff >= cfg.timeout_ticks) begin
               result.valid     = 1'b1;
               result.timed_out = 1'b1;
               result.char_data = '0;
            end
         end
         PH_IDLE: begin
            result.valid = rx_level || (idle_inc >= idle_limit);
         end
         PH_STOP: begin
            result.valid = (offset_inc >= stop_target) && rx_level;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      idle_in    = idle_ff;
      hunt_in    = hunt_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (result.valid) begin
               hunt_in = '0;
            end else begin
               hunt_in = hunt_bump;
               if (!rx_level) begin
                  phase_in   = PH_CONFIRM;
                  offset_in  = '0;
                  bit_idx_in = '0;
                  shift_in   = '0;
                  idle_in    = '0;
               end
            end
         end
         PH_CONFIRM: begin
            offset_in = offset_inc;
            hunt_in   = hunt_bump;
            if (offset_inc >= {4'd0, half}) begin
               if (rx_level) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in   = PH_DATA;
                  bit_idx_in = '0;
                  shift_in   = '0;
               end
            end
         end
         PH_DATA: begin
            offset_in = offset_inc;
            if (offset_inc >= data_target) begin
               shift_in   = shift_ff | (CharW'(rx_level) << bit_idx_ff[2:0]);
               bit_idx_in = bit_idx_inc;
               if (bit_idx_inc >= nbits) begin
                  phase_in = PH_STOP;
               end
            end
         end
         PH_STOP: begin
            offset_in = offset_inc;
            if (result.valid) begin
               phase_in = PH_HUNT;
               hunt_in  = '0;
            end else if (offset_inc >= stop_target) begin
               phase_in = PH_IDLE;
               idle_in  = '0;
            end
         end
         PH_IDLE: begin
            idle_in = idle_inc;
            if (result.valid) begin
               phase_in = PH_HUNT;
               hunt_in  = '0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         offset_ff  <= '0;
         bit_idx_ff <= '0;
         shift_ff   <= '0;
         idle_ff    <= '0;
         hunt_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         idle_ff    <= idle_in;
         hunt_ff    <= hunt_in;
      end
   end

   // a character always sends the receiver back to hunting with a fresh count
   a_char_restarts_hunt: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && !result.timed_out |=> phase_ff == PH_HUNT && hunt_ff == '0)
      else $error("character result did not restart hunting");

   // timeouts only come out of the hunting phase
   a_timeout_from_hunt: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.timed_out |-> phase_ff == PH_HUNT)
      else $error("timeout outside hunting");

   a_data_index_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bit_idx_ff < NBITS_8N1)
      else $error("bit index out of range in data phase");

endmodule

// ----- rtl/serial_rx_midbit_sampler_top.sv -----
// ----------------------------------------------------------------------------
// serial_rx_midbit_sampler_top - tick-driven 7E1 / 8N1 serial receiver
// Configuration registers, line tick intake and registered result output.
// ----------------------------------------------------------------------------
// Each req item is one line tick (req_tdata[0] = sampled level). The block
// takes one tick per clock: the whole frame update is a single pass from the
// frame state registers through the compare logic back into them, and a
// character or timeout produced by a tick appears on rsp in the next cycle
// from the output register. req_tready drops only while that register holds
// a result that rsp_tready is not taking. Write configuration via csr_* only
// while the line is idle and no result is pending.
// ----------------------------------------------------------------------------
module serial_rx_midbit_sampler_top
   import srx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input ticks
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] rx_level, [7:1] zero fill
   // results
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CharW-1:0]     rsp_tdata,   // [7:0] char_data
   output logic                 rsp_tuser,   // [0] timed_out
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   srx_cfg_type    cfg_ff;
   srx_result_type result;
   logic           step;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [CharW-1:0] rsp_data_ff;
   logic             rsp_user_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks     <= BIT_TICKS_RST;
         cfg_ff.frame_mode    <= FRAME_MODE_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BIT_TICKS:     cfg_ff.bit_ticks     <= csr_data[BitTicksW-1:0];
            CSR_FRAME_MODE:    cfg_ff.frame_mode    <= csr_data[0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data[TimeoutW-1:0];
            default: begin
            end
         endcase
      end
   end

   srx_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_level (req_tdata[0]),
      .cfg      (cfg_ff),
      .result   (result)
   );

   always_comb begin
      priority if (step && result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         rsp_data_ff <= result.char_data;
         rsp_user_ff <= result.timed_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a held result must block new ticks, or a second result would overwrite it
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("tick accepted while result stalled");

   a_timeout_zero_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_data_ff == '0)
      else $error("timeout result carries character data");

   a_seven_bit_clear: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && !cfg_ff.frame_mode |=> !rsp_data_ff[CharW-1])
      else $error("bit 7 set in seven-bit mode");

endmodule
